// ----- sv/sfmx_pkg.sv -----
// sfmx_pkg: word types, command and status structs, constants and the
// fractional exponential table for the softmax normaliser
// no dependencies
package sfmx_pkg;

  // input word: one logit, signed q8.8
  typedef struct packed {
    logic signed [15:0] logit;
    logic               last;
  } in_word_t;

  // output word: one class probability
  typedef struct packed {
    logic [15:0] probability;
    logic [3:0]  class_index;
    logic [3:0]  top_class;
    logic        overflow;
    logic        final_result;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic clr_vec;
    logic idx_clr;
    logic idx_inc;
    logic sum_clr;
    logic exp_init;
    logic exp_mul;
    logic exp_wr;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;
    logic n_zero;
    logic step_last;
    logic out_free;
  } status_t;

  // e^-1 in q0.32
  localparam logic [30:0] E1_Q32 = 31'd1580030169;
  // differences beyond -16.0 in q8.8 give zero
  localparam logic [16:0] EXP_CUTOFF = 17'd4096;
  // final step index of the 17-step divider
  localparam logic [4:0] DIV_LAST_STEP = 5'd16;
  // one in q0.32
  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

  typedef logic [32:0] exp_frac_tbl_t [256];

  // exp(-f/256) in q0.32, taylor series to x^12/12!, each term truncated
  function automatic logic [32:0] exp_frac(input logic [7:0] f);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [64:0] s;
    x    = {32'd0, f, 24'd0};
    term = ONE_Q32;
    s    = $signed({1'b0, ONE_Q32});
    term = (term * x) >> 32;         s = s - $signed({1'b0, term});
    term = ((term * x) >> 32) / 2;   s = s + $signed({1'b0, term});
    term = ((term * x) >> 32) / 3;   s = s - $signed({1'b0, term});
    term = ((term * x) >> 32) / 4;   s = s + $signed({1'b0, term});
    term = ((term * x) >> 32) / 5;   s = s - $signed({1'b0, term});
    term = ((term * x) >> 32) / 6;   s = s + $signed({1'b0, term});
    term = ((term * x) >> 32) / 7;   s = s - $signed({1'b0, term});
    term = ((term * x) >> 32) / 8;   s = s + $signed({1'b0, term});
    term = ((term * x) >> 32) / 9;   s = s - $signed({1'b0, term});
    term = ((term * x) >> 32) / 10;  s = s + $signed({1'b0, term});
    term = ((term * x) >> 32) / 11;  s = s - $signed({1'b0, term});
    term = ((term * x) >> 32) / 12;  s = s + $signed({1'b0, term});
    // clamp to [0, 1.0]
    if (s < 0) begin
      s = '0;
    end
    if (s > $signed({1'b0, ONE_Q32})) begin
      s = $signed({1'b0, ONE_Q32});
    end
    return s[32:0];
  endfunction

  function automatic exp_frac_tbl_t build_exp_frac();
    exp_frac_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = exp_frac(8'(i));
    end
    return t;
  endfunction

  // fractional exponential table, built at elaboration
  localparam exp_frac_tbl_t EXP_FRAC_TBL = build_exp_frac();

endpackage

// ----- sv/softmax_normalizer_unit.sv -----
// softmax_normalizer_unit: max-subtracted softmax over up to MAX_CLASSES logits
// depends on sfmx_pkg, sfmx_ctrl, sfmx_datapath
//
//   channel | direction | handshake                  | word
//   in      | input     | in_valid_i / in_stall_o    | sfmx_pkg::in_word_t
//   out     | output    | out_valid_o / out_stall_i  | sfmx_pkg::out_word_t
//
// one logit word is taken per cycle while loading; the word marked last
// starts the exponential pass: per stored logit a read, a table seed, n
// e^-1 multiplies at one per cycle (n = whole part of the distance below the
// maximum, at most 16) and a write; per class the division pass does the
// read, seed, 17 restoring steps and hand-off to the output register.
// reset clears the fill count, running maximum, flags and output valid.
// a stalled output holds the divider at hand-off; the next vector's words are
// taken as soon as the final result sits in the output register.
module softmax_normalizer_unit #(
  parameter int MAX_CLASSES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sfmx_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfmx_pkg::out_word_t out_word_o
);

  sfmx_pkg::cmd_t    cmd;
  sfmx_pkg::status_t st;

  // sequencer
  sfmx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.last),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // stores, arithmetic and output register
  sfmx_datapath #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- sv/sfmx_ctrl.sv -----
// sfmx_ctrl: sequencer for load, exponential and division passes
// depends on sfmx_pkg (cmd_t, status_t)
module sfmx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_stall_o,
  input  sfmx_pkg::status_t st_i,
  output sfmx_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_EXP_RD   = 4'd1;
  localparam logic [3:0] S_EXP_K    = 4'd2;
  localparam logic [3:0] S_EXP_MUL  = 4'd3;
  localparam logic [3:0] S_EXP_ACC  = 4'd4;
  localparam logic [3:0] S_DIV_RD   = 4'd5;
  localparam logic [3:0] S_DIV_INIT = 4'd6;
  localparam logic [3:0] S_DIV_STEP = 4'd7;
  localparam logic [3:0] S_DIV_OUT  = 4'd8;

  logic [3:0] state_q, state_d;

  // input is taken only while loading
  assign in_stall_o = (state_q != S_LOAD);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          if (in_last_i) begin
            cmd_o.idx_clr = 1'b1;
            cmd_o.sum_clr = 1'b1;
            state_d       = S_EXP_RD;
          end
        end
      end
      S_EXP_RD: begin
        state_d = S_EXP_K;
      end
      S_EXP_K: begin
        cmd_o.exp_init = 1'b1;
        state_d        = S_EXP_MUL;
      end
      S_EXP_MUL: begin
        if (st_i.n_zero) begin
          state_d = S_EXP_ACC;
        end else begin
          cmd_o.exp_mul = 1'b1;
        end
      end
      S_EXP_ACC: begin
        cmd_o.exp_wr = 1'b1;
        if (st_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_DIV_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_EXP_RD;
        end
      end
      S_DIV_RD: begin
        state_d = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        if (st_i.step_last) begin
          state_d = S_DIV_OUT;
        end
      end
      S_DIV_OUT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (st_i.idx_last) begin
            cmd_o.clr_vec = 1'b1;
            state_d       = S_LOAD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_DIV_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // a held result blocks the divider's hand-off
  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_OUT && !st_i.out_free) |=> (state_q == S_DIV_OUT))
    else $error("result hand-off left while output busy");

  // the closing word of a vector starts the exponential pass
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && in_valid_i && in_last_i) |=> (state_q == S_EXP_RD))
    else $error("closing word did not start exponential pass");

endmodule

// ----- sv/sfmx_datapath.sv -----
// sfmx_datapath: logit and exponential stores, running maximum, exponential
// unit, accumulator, 17-step divider and output register
// depends on sfmx_pkg (word types, cmd_t, status_t, EXP_FRAC_TBL)
module sfmx_datapath #(
  parameter int MAX_CLASSES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfmx_pkg::in_word_t  in_word_i,
  input  sfmx_pkg::cmd_t      cmd_i,
  output sfmx_pkg::status_t   st_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output sfmx_pkg::out_word_t out_word_o
);

  localparam int IDX_W = $clog2(MAX_CLASSES);
  localparam int CNT_W = $clog2(MAX_CLASSES + 1);
  localparam int SUM_W = IDX_W + 17;

  // stores
  logic signed [15:0] logit_mem [MAX_CLASSES];
  logic [16:0]        exp_mem   [MAX_CLASSES];
  logic signed [15:0] logit_rd_q;
  logic [16:0]        exp_rd_q;

  // vector state
  logic [CNT_W-1:0]   cnt_q;
  logic signed [15:0] max_q;
  logic [IDX_W-1:0]   max_idx_q;
  logic               drop_q;
  logic [IDX_W-1:0]   idx_q;
  logic [SUM_W-1:0]   sum_q;

  // exponential unit
  logic [32:0]        v_q;
  logic [4:0]         n_q;
  logic               zero_q;

  // divider
  logic [SUM_W-1:0]   rem_q;
  logic [16:0]        num_q;
  logic [16:0]        quo_q;
  logic [4:0]         step_q;

  // output register
  logic                out_valid_q;
  sfmx_pkg::out_word_t out_q;

  logic               room;
  logic [IDX_W-1:0]   cnt_idx;
  logic [16:0]        k_diff;
  logic               k_big;
  logic [63:0]        mul_w;
  logic [63:0]        mul_rnd;
  logic [33:0]        v_rnd;
  logic [16:0]        e_val;
  logic [SUM_W:0]     trial;
  logic [SUM_W:0]     trial_sub;
  logic               trial_ge;
  logic [IDX_W+3:0]   cls_ext;
  logic [IDX_W+3:0]   top_ext;

  // load side
  assign room    = (cnt_q < CNT_W'(MAX_CLASSES));
  assign cnt_idx = cnt_q[IDX_W-1:0];

  // distance below the maximum, q8.8
  assign k_diff = {max_q[15], max_q} - {logit_rd_q[15], logit_rd_q};
  assign k_big  = (k_diff > sfmx_pkg::EXP_CUTOFF);

  // one e^-1 step, rounded half up
  assign mul_w   = 64'(v_q) * 64'(sfmx_pkg::E1_Q32);
  assign mul_rnd = mul_w + 64'h0000_0000_8000_0000;

  // round to q1.16
  assign v_rnd = 34'(v_q) + 34'd32768;
  assign e_val = zero_q ? 17'd0 : v_rnd[32:16];

  // restoring divide step
  assign trial     = {rem_q, num_q[16]};
  assign trial_ge  = (trial >= {1'b0, sum_q});
  assign trial_sub = trial - {1'b0, sum_q};

  // logit store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item && room) begin
      logit_mem[cnt_idx] <= in_word_i.logit;
    end
    logit_rd_q <= logit_mem[idx_q];
  end

  // exponential store
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_wr) begin
      exp_mem[idx_q] <= e_val;
    end
    exp_rd_q <= exp_mem[idx_q];
  end

  // vector control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      max_q     <= '0;
      max_idx_q <= '0;
      drop_q    <= 1'b0;
      idx_q     <= '0;
      sum_q     <= '0;
      step_q    <= '0;
    end else begin
      if (cmd_i.clr_vec) begin
        cnt_q     <= '0;
        max_q     <= '0;
        max_idx_q <= '0;
        drop_q    <= 1'b0;
      end else if (cmd_i.load_item) begin
        if (room) begin
          if (cnt_q == '0 || in_word_i.logit > max_q) begin
            max_q     <= in_word_i.logit;
            max_idx_q <= cnt_idx;
          end
          cnt_q <= cnt_q + CNT_W'(1);
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.sum_clr) begin
        sum_q <= '0;
      end else if (cmd_i.exp_wr) begin
        sum_q <= sum_q + SUM_W'(e_val);
      end
      if (cmd_i.div_init) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + 5'd1;
      end
    end
  end

  // exponential unit: table seed, then one e^-1 multiply per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_init) begin
      zero_q <= k_big;
      n_q    <= k_big ? 5'd0 : k_diff[12:8];
      v_q    <= sfmx_pkg::EXP_FRAC_TBL[k_diff[7:0]];
    end else if (cmd_i.exp_mul) begin
      n_q <= n_q - 5'd1;
      v_q <= {1'b0, mul_rnd[63:32]};
    end
  end

  // divider: (e << 16) / sum, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= SUM_W'(exp_rd_q[16:1]);
      num_q <= {exp_rd_q[0], 16'd0};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
      num_q <= {num_q[15:0], 1'b0};
      quo_q <= {quo_q[15:0], trial_ge};
    end
  end

  // class numbers folded to four bits
  assign cls_ext = {4'd0, idx_q};
  assign top_ext = {4'd0, max_idx_q};

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.probability  <= quo_q[16] ? 16'hFFFF : quo_q[15:0];
      out_q.class_index  <= cls_ext[3:0];
      out_q.top_class    <= top_ext[3:0];
      out_q.overflow     <= drop_q;
      out_q.final_result <= st_o.idx_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // status back to the controller
  assign st_o.idx_last  = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));
  assign st_o.n_zero    = (n_q == 5'd0);
  assign st_o.step_last = (step_q == sfmx_pkg::DIV_LAST_STEP);
  assign st_o.out_free  = !out_valid_q || !out_stall_i;

  // fill count never passes capacity
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_CLASSES))
    else $error("fill count beyond capacity");

  // partial remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < sum_q))
    else $error("divider remainder not below sum");

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for softmax_normalizer_unit with a built-in softmax predictor
// depends on sfmx_pkg and softmax_normalizer_unit; a queue-fed driver and a monitor check
// every output word in order against the predicted class probabilities
`timescale 1ns / 1ps

module testbench;

  localparam int CLASSES = 16;
  // e^-1 in q0.32 and the rounding constant for a q0.32 multiply
  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;
  localparam logic [63:0] HALF_Q32   = 64'h8000_0000;
  localparam logic [63:0] UNITY_Q32  = 64'h1_0000_0000;
  localparam int HOLD_LEN    = 1500;
  localparam int TAIL_CYCLES = 700;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {STYLE_WIDE, STYLE_CLUSTER, STYLE_TIES} vec_style_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  sfmx_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  sfmx_pkg::out_word_t out_word_o;

  // words waiting to be sent and probabilities waiting to arrive
  sfmx_pkg::in_word_t  pending_logits[$];
  sfmx_pkg::out_word_t predicted_probs[$];
  sfmx_pkg::out_word_t next_expected;

  // predictor copy of the vector state
  logic signed [15:0] held_logits [CLASSES];
  int                 held_count   = 0;
  logic signed [15:0] run_max      = '0;
  logic [3:0]         run_max_idx  = '0;
  logic               dropped_seen = 1'b0;

  int words_taken    = 0;
  int words_seen     = 0;
  int fault_count    = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit hold_arm       = 1'b0;
  bit hold_used      = 1'b0;

  softmax_normalizer_unit #(
    .MAX_CLASSES(CLASSES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // exp(-f/256) in q0.32 from a truncated taylor series, clamped to [0, 1.0]
  function automatic logic [63:0] exp_fraction_q32(input logic [7:0] f);
    logic [63:0] x;
    logic [63:0] term;
    longint      acc;
    x    = {32'd0, f, 24'd0};
    term = UNITY_Q32;
    acc  = longint'(UNITY_Q32);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x) >> 32) / 64'(n);
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(UNITY_Q32)) begin
      acc = longint'(UNITY_Q32);
    end
    return 64'(acc);
  endfunction

  // exp(-k/256) in q1.16, zero beyond a distance of 16.0
  function automatic logic [16:0] exp_neg_q1_16(input logic [31:0] k);
    logic [63:0] v;
    if (k > 32'd4096) begin
      return '0;
    end
    v = exp_fraction_q32(k[7:0]);
    for (int i = 0; i < int'(k >> 8); i++) begin
      v = (v * EXP_M1_Q32 + HALF_Q32) >> 32;
    end
    return 17'((v + 64'd32768) >> 16);
  endfunction

  // store one logit; a last word produces the whole vector of probabilities
  task automatic absorb_logit(input sfmx_pkg::in_word_t w);
    logic [16:0]         exps [CLASSES];
    logic [20:0]         total;
    logic [63:0]         p;
    sfmx_pkg::out_word_t r;
    if (held_count < CLASSES) begin
      held_logits[held_count] = w.logit;
      if (held_count == 0 || w.logit > run_max) begin
        run_max     = w.logit;
        run_max_idx = 4'(held_count);
      end
      held_count++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (!w.last) begin
      return;
    end
    total = '0;
    for (int i = 0; i < held_count; i++) begin
      exps[i] = exp_neg_q1_16(32'(int'(run_max) - int'(held_logits[i])));
      total   = total + 21'(exps[i]);
    end
    for (int i = 0; i < held_count; i++) begin
      p = (64'(exps[i]) << 16) / 64'(total);
      if (p > 64'd65535) begin
        p = 64'd65535;
      end
      r.probability  = p[15:0];
      r.class_index  = 4'(i);
      r.top_class    = run_max_idx;
      r.overflow     = dropped_seen;
      r.final_result = (i == held_count - 1);
      predicted_probs = {predicted_probs, r};
    end
    held_count   = 0;
    run_max      = '0;
    run_max_idx  = '0;
    dropped_seen = 1'b0;
  endtask

  task automatic queue_logit(input logic signed [15:0] v, input logic fin);
    sfmx_pkg::in_word_t w;
    w.logit = v;
    w.last  = fin;
    pending_logits = {pending_logits, w};
  endtask

  // one vector whose last word is flagged
  task automatic queue_vector(input int len, input vec_style_e style);
    int base;
    int spread;
    int val;
    base = int'($urandom_range(65535, 0)) - 32768;
    case ($urandom_range(3, 0))
      0: spread = 200;
      1: spread = 1200;
      2: spread = 4200;
      default: spread = 9000;
    endcase
    for (int i = 0; i < len; i++) begin
      case (style)
        STYLE_WIDE: val = int'($urandom_range(65535, 0)) - 32768;
        STYLE_CLUSTER: val = base + int'($urandom_range(2 * spread, 0)) - spread;
        default: val = base - 256 * int'($urandom_range(2, 0));
      endcase
      if (val > 32767) begin
        val = 32767;
      end
      if (val < -32768) begin
        val = -32768;
      end
      queue_logit(16'(val), i == len - 1);
    end
  endtask

  // random vectors, mostly in capacity, some running over it
  task automatic queue_random_vectors(input int target);
    int count;
    int len;
    int pick;
    count = 0;
    while (count < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        len = $urandom_range(20, 17);
      end else if (pick < 18) begin
        len = CLASSES;
      end else begin
        len = $urandom_range(CLASSES - 1, 1);
      end
      queue_vector(len, vec_style_e'($urandom_range(2, 0)));
      count += len;
    end
  endtask

  task automatic wait_drained();
    while (pending_logits.size() != 0 || predicted_probs.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // input acceptance feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      absorb_logit(in_word_i);
      void'(pending_logits.pop_front());
      words_taken++;
    end
  end

  // output check against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_probs.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected word: prob %0d class %0d top %0d ovf %0b fin %0b",
                   out_word_o.probability, out_word_o.class_index, out_word_o.top_class,
                   out_word_o.overflow, out_word_o.final_result);
        end
      end else begin
        next_expected = predicted_probs.pop_front();
        if (out_word_o.probability !== next_expected.probability ||
            out_word_o.class_index !== next_expected.class_index ||
            out_word_o.top_class !== next_expected.top_class ||
            out_word_o.overflow !== next_expected.overflow ||
            out_word_o.final_result !== next_expected.final_result) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: exp prob %0d class %0d top %0d ovf %0b fin %0b",
                     next_expected.probability, next_expected.class_index,
                     next_expected.top_class, next_expected.overflow,
                     next_expected.final_result);
            $display("          got prob %0d class %0d top %0d ovf %0b fin %0b",
                     out_word_o.probability, out_word_o.class_index, out_word_o.top_class,
                     out_word_o.overflow, out_word_o.final_result);
          end
        end
      end
    end
  end

  // sender: hold a stalled word, otherwise offer the next one or idle
  always @(negedge clk_i) begin
    if (!(in_valid_i && words_taken == words_seen)) begin
      words_seen = words_taken;
      if (pending_logits.size() != 0 && int'($urandom_range(99, 0)) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_word_i  <= pending_logits[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(negedge clk_i) begin
    if (hold_arm && !hold_used) begin
      hold_left <= HOLD_LEN;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= (hold_left != 0) || (int'($urandom_range(99, 0)) < recv_stall_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** softmax_normalizer_unit: FAILED **");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: single class saturates, tie picks the lower index
    queue_logit(16'sh0100, 1'b1);
    queue_logit(16'sd512, 1'b0);
    queue_logit(16'sd512, 1'b1);
    // extremes of the logit range
    queue_logit(16'sd32767, 1'b0);
    queue_logit(-16'sd32768, 1'b1);
    // exactly sixteen below the maximum survives, just past it gives zero
    queue_logit(16'sd0, 1'b0);
    queue_logit(-16'sd4096, 1'b0);
    queue_logit(-16'sd4097, 1'b1);
    // over capacity, the dropped last word is the largest and still ends the vector
    for (int i = 0; i <= CLASSES; i++) begin
      queue_logit(16'(-2000 + 171 * i), i == CLASSES);
    end
    wait_drained();

    // random phases: free running, sender idle, receiver stall, both
    queue_random_vectors(24);
    wait_drained();
    send_idle_pct = 84;
    queue_random_vectors(24);
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 84;
    queue_random_vectors(24);
    wait_drained();
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    queue_random_vectors(24);
    wait_drained();

    // receiver held off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_arm       = 1'b1;
    queue_vector(CLASSES, STYLE_CLUSTER);
    queue_random_vectors(14);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("** softmax_normalizer_unit: PASSED **");
    end else begin
      $display("** softmax_normalizer_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/sfmx_pkg.sv
sv/sfmx_ctrl.sv
sv/sfmx_datapath.sv
sv/softmax_normalizer_unit.sv
tb/testbench.sv
